[sv/fbpa_pkg.sv]
package fbpa_pkg;

	localparam int ADDR_W     = 32;
	localparam int BB_W       = 13;
	localparam int PB_W       = 7;
	localparam int CNT_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Header word size of a block; a power of two so rounding is a mask.
	localparam int WORD_BYTES = 4;
	localparam int WORD_SHIFT = 2;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_BLOCK = 2'd1,
		STATUS_NULL     = 2'd2,
		STATUS_OVERFLOW = 2'd3
	} status_t;

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BLOCKS = 2'd2;

endpackage

[sv/fbpa_req_if.sv]
interface fbpa_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [fbpa_pkg::ADDR_W-1:0] release_addr;

	modport source (output valid, output req_type, output release_addr, input ready);
	modport sink (input valid, input req_type, input release_addr, output ready);
endinterface

[sv/fbpa_rsp_if.sv]
interface fbpa_rsp_if;
	logic                        valid;
	logic                        ready;
	fbpa_pkg::status_t           status;
	logic [fbpa_pkg::ADDR_W-1:0] block_addr;
	logic [fbpa_pkg::CNT_W-1:0]  free_count;

	modport source (output valid, output status, output block_addr, output free_count,
		input ready);
	modport sink (input valid, input status, input block_addr, input free_count,
		output ready);
endinterface

[sv/fixed_block_pool_allocator_unit.sv]
// Fixed-size block pool allocator. One request word is taken per clock cycle and its
// response word appears in the output register on the next cycle; the unit keeps taking
// requests while that response waits, as long as the response side takes it in the same
// cycle. Allocation pops the most recently released address from a free stack, else carves
// the next block from the pool at base_addr; release pushes a non-null address unless
// every block is already free. The stack lives in a MAX_BLOCKS-entry memory with one
// write and one registered read port; its two topmost entries are also held in registers
// so that pops and pushes can run back to back. There is no clearing pass after reset.
module fixed_block_pool_allocator_unit #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fbpa_req_if.sink                        req,
	fbpa_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int UW = (CW > fbpa_pkg::PB_W) ? CW : fbpa_pkg::PB_W;
	localparam int FW = UW + 1;
	localparam int AD = fbpa_pkg::ADDR_W;

	logic [AD-1:0]               base_q;
	logic [fbpa_pkg::BB_W-1:0]   block_bytes_q;
	logic [fbpa_pkg::PB_W-1:0]   pool_blocks_q;

	logic [CW-1:0]               sp_q, sp_n;
	logic [CW-1:0]               carved_q, carved_n;
	logic [AD-1:0]               offset_q, offset_n;
	logic [AD-1:0]               tos_q;
	logic [AD-1:0]               below_q;
	logic [AD-1:0]               stack_mem [MAX_BLOCKS];

	logic                        out_valid_q;
	fbpa_pkg::status_t           status_q;
	logic [AD-1:0]               addr_q;
	logic [fbpa_pkg::CNT_W-1:0]  count_q;

	logic                        accept;
	logic                        do_pop, do_push;
	fbpa_pkg::status_t           status_c;
	logic [AD-1:0]               addr_c;
	logic [UW-1:0]               usable;
	logic [UW-1:0]               left_cur, left_nxt;
	logic [FW-1:0]               free_cur, free_nxt;
	logic [fbpa_pkg::CNT_W-1:0]  count_c;
	logic [fbpa_pkg::BB_W:0]     bb_up;
	logic [fbpa_pkg::BB_W:0]     bb_round;
	logic [AD-1:0]               full_size;
	logic [CW-1:0]               sp_m3;

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.block_addr = addr_q;
	assign rsp.free_count = count_q;

	// Header word plus the user size rounded up to whole words.
	assign bb_up     = {1'b0, block_bytes_q} + (fbpa_pkg::BB_W + 1)'(fbpa_pkg::WORD_BYTES - 1);
	assign bb_round  = {bb_up[fbpa_pkg::BB_W:fbpa_pkg::WORD_SHIFT],
		{fbpa_pkg::WORD_SHIFT{1'b0}}};
	assign full_size = AD'(bb_round) + AD'(fbpa_pkg::WORD_BYTES);

	assign usable = (UW'(pool_blocks_q) < UW'(MAX_BLOCKS)) ? UW'(pool_blocks_q)
		: UW'(MAX_BLOCKS);
	assign left_cur = (usable > UW'(carved_q)) ? usable - UW'(carved_q) : '0;
	assign free_cur = FW'(sp_q) + FW'(left_cur);

	always_comb begin
		sp_n     = sp_q;
		carved_n = carved_q;
		offset_n = offset_q;
		do_pop   = 1'b0;
		do_push  = 1'b0;
		status_c = fbpa_pkg::STATUS_OK;
		addr_c   = '0;
		if (req.req_type == fbpa_pkg::REQ_ALLOC) begin
			priority if (sp_q != '0) begin
				do_pop = 1'b1;
				addr_c = tos_q;
				sp_n   = sp_q - CW'(1);
			end else if (left_cur != '0) begin
				addr_c   = base_q + offset_q + AD'(fbpa_pkg::WORD_BYTES);
				offset_n = offset_q + full_size;
				carved_n = carved_q + CW'(1);
			end else begin
				status_c = fbpa_pkg::STATUS_NO_BLOCK;
			end
		end else begin
			priority if (req.release_addr == '0) begin
				status_c = fbpa_pkg::STATUS_NULL;
			end else if (sp_q >= CW'(MAX_BLOCKS) || free_cur >= FW'(usable)) begin
				status_c = fbpa_pkg::STATUS_OVERFLOW;
			end else begin
				do_push = 1'b1;
				sp_n    = sp_q + CW'(1);
			end
		end
	end

	assign left_nxt = (usable > UW'(carved_n)) ? usable - UW'(carved_n) : '0;
	assign free_nxt = FW'(sp_n) + FW'(left_nxt);
	assign count_c  = (free_nxt > FW'(127)) ? fbpa_pkg::CNT_W'(127)
		: free_nxt[fbpa_pkg::CNT_W-1:0];

	// After a pop the new second entry sits three below the old stack pointer.
	assign sp_m3 = sp_q - CW'(3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q        <= '0;
			block_bytes_q <= fbpa_pkg::BB_W'(4);
			pool_blocks_q <= fbpa_pkg::PB_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fbpa_pkg::CFG_BASE_ADDR:   base_q        <= cfg_data;
				fbpa_pkg::CFG_BLOCK_BYTES: block_bytes_q <= cfg_data[fbpa_pkg::BB_W-1:0];
				fbpa_pkg::CFG_POOL_BLOCKS: pool_blocks_q <= cfg_data[fbpa_pkg::PB_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			carved_q    <= '0;
			offset_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				out_valid_q <= req.valid;
			end
			if (accept) begin
				sp_q     <= sp_n;
				carved_q <= carved_n;
				offset_q <= offset_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_c;
			addr_q   <= addr_c;
			count_q  <= count_c;
			if (do_push) begin
				tos_q <= req.release_addr;
			end else if (do_pop) begin
				tos_q <= below_q;
			end
		end
	end

	// Stack memory: every push is written at its own slot, the read port refills the
	// second-from-top register when a pop moves the stack down.
	always_ff @(posedge clk) begin
		if (accept && do_push) begin
			stack_mem[sp_q[AW-1:0]] <= req.release_addr;
			below_q                 <= tos_q;
		end else if (accept && do_pop) begin
			below_q <= stack_mem[sp_m3[AW-1:0]];
		end
	end

endmodule

[sv/fbpa_checker.sv]
module fbpa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [1:0]                  rsp_status,
	input logic [fbpa_pkg::ADDR_W-1:0] rsp_block_addr
);

	// A response word must not disappear while it is stalled.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response word dropped while stalled");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted request gave no response word");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request side stalled without an output stall");

	a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != 2'(fbpa_pkg::STATUS_OK) |-> rsp_block_addr == '0)
		else $error("failed request returned a block address");

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_block_addr(rsp.block_addr)
);
